// ===== hw/rtl/dq_pkg.sv =====
// shared types and constants for the double-ended queue core
// no dependencies; used by dq_ctrl, dq_datapath and double_ended_queue_core
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // stream widths, payload padded to whole bytes
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_FIND       = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    in_load;
        logic    wr_back;
        logic    wr_front;
        logic    rd_back;
        logic    rd_front;
        logic    clr;
        logic    scan_first;
        logic    scan_next;
        logic    out_load;
        status_t out_status;
        logic    out_pop;
        logic    out_pos;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             hit;
        logic             scan_last;
        logic             out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dq_ctrl.sv =====
// command sequencer for the double-ended queue core
// depends on dq_pkg for command codes, status codes and the control structs
`default_nettype none

module dq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire dq_pkg::dp_stat_t stat,
    output dq_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    dq_pkg::status_t pend_status_reg, pend_status_next;
    logic            pend_pop_reg, pend_pop_next;
    logic            pend_pos_reg, pend_pos_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pend_status_reg <= dq_pkg::ST_OK;
            pend_pop_reg    <= 1'b0;
            pend_pos_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_status_reg <= pend_status_next;
            pend_pop_reg    <= pend_pop_next;
            pend_pos_reg    <= pend_pos_next;
        end
    end

    always_comb
    begin
        dq_pkg::status_t fin_status;
        logic            fin_now;

        state_next       = state_reg;
        pend_status_next = pend_status_reg;
        pend_pop_next    = pend_pop_reg;
        pend_pos_next    = pend_pos_reg;
        cmd              = '0;
        s_tready         = 1'b0;
        fin_status       = dq_pkg::ST_OK;
        fin_now          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (stat.cmd)
                    dq_pkg::CMD_PUSH_BACK:
                    begin
                        fin_now = 1'b1;
                        if (stat.full)
                        begin
                            fin_status = dq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_back = 1'b1;
                        end
                    end
                    dq_pkg::CMD_PUSH_FRONT:
                    begin
                        fin_now = 1'b1;
                        if (stat.full)
                        begin
                            fin_status = dq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_front = 1'b1;
                        end
                    end
                    dq_pkg::CMD_POP_BACK,
                    dq_pkg::CMD_POP_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            fin_now    = 1'b1;
                            fin_status = dq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            // read data lands in the next cycle
                            cmd.rd_back      = (stat.cmd == dq_pkg::CMD_POP_BACK);
                            cmd.rd_front     = (stat.cmd == dq_pkg::CMD_POP_FRONT);
                            pend_status_next = dq_pkg::ST_OK;
                            pend_pop_next    = 1'b1;
                            pend_pos_next    = 1'b0;
                            state_next       = S_DONE;
                        end
                    end
                    dq_pkg::CMD_FIND:
                    begin
                        if (stat.empty)
                        begin
                            fin_now    = 1'b1;
                            fin_status = dq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.scan_first = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    dq_pkg::CMD_CLEAR:
                    begin
                        fin_now = 1'b1;
                        cmd.clr = 1'b1;
                    end
                    default:
                    begin
                        fin_now = 1'b1;
                    end
                endcase

                if (fin_now)
                begin
                    if (stat.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = fin_status;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        pend_status_next = fin_status;
                        pend_pop_next    = 1'b0;
                        pend_pos_next    = 1'b0;
                        state_next       = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                if (stat.hit)
                begin
                    pend_status_next = dq_pkg::ST_OK;
                    pend_pop_next    = 1'b0;
                    pend_pos_next    = 1'b1;
                    state_next       = S_DONE;
                end
                else if (stat.scan_last)
                begin
                    pend_status_next = dq_pkg::ST_NOT_FOUND;
                    pend_pop_next    = 1'b0;
                    pend_pos_next    = 1'b0;
                    state_next       = S_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end

            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = pend_status_reg;
                    cmd.out_pop    = pend_pop_reg;
                    cmd.out_pos    = pend_pos_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dq_datapath.sv =====
// ring store, head and occupancy pointers, scan counters and output register
// depends on dq_pkg for widths, codes and the control structs
`default_nettype none

module dq_datapath #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [dq_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [dq_pkg::S_USER_W-1:0] s_tuser,
    input  wire dq_pkg::dp_cmd_t             cmd,
    output dq_pkg::dp_stat_t                 stat,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [dq_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [dq_pkg::M_USER_W-1:0]      m_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
    localparam int PAD_W = dq_pkg::M_DATA_W - dq_pkg::VALUE_W - dq_pkg::POS_W
                           - dq_pkg::COUNT_W;

    logic [dq_pkg::VALUE_W-1:0] ring_mem [DEPTH];

    logic [dq_pkg::CMD_W-1:0]   cmd_reg;
    logic [dq_pkg::VALUE_W-1:0] val_reg;
    logic [AW-1:0]              head_reg, head_next;
    logic [CW-1:0]              occ_reg, occ_next;
    logic [AW-1:0]              scan_addr_reg, scan_addr_next;
    logic [AW-1:0]              cmp_idx_reg, cmp_idx_next;
    logic [dq_pkg::VALUE_W-1:0] rd_data_reg;

    logic                        out_valid_reg;
    logic [dq_pkg::VALUE_W-1:0]  out_value_reg;
    logic [dq_pkg::POS_W-1:0]    out_pos_reg;
    logic [dq_pkg::STATUS_W-1:0] out_status_reg;
    logic [dq_pkg::COUNT_W-1:0]  out_count_reg;

    logic [AW-1:0] head_inc, head_dec, scan_inc;
    logic [AW-1:0] ring_off, ring_addr;
    logic [AW:0]   ring_sum;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [AW:0]   cmp_plus, occ_ext;
    logic [AW+3:0] idx_ext;
    logic [CW+4:0] count_ext;

    // ring pointer arithmetic, one compare and subtract for the wrap
    assign head_inc = (head_reg == LAST_A) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_A : head_reg - 1'b1;
    assign scan_inc = (scan_addr_reg == LAST_A) ? '0 : scan_addr_reg + 1'b1;
    assign ring_off = cmd.rd_back ? AW'(occ_reg - 1'b1) : AW'(occ_reg);
    assign ring_sum = {1'b0, head_reg} + {1'b0, ring_off};
    assign ring_addr = (ring_sum >= DEPTH_W) ? AW'(ring_sum - DEPTH_W) : ring_sum[AW-1:0];

    assign wr_en   = cmd.wr_back | cmd.wr_front;
    assign wr_addr = cmd.wr_front ? head_dec : ring_addr;
    assign rd_en   = cmd.rd_back | cmd.rd_front | cmd.scan_first | cmd.scan_next;
    assign rd_addr = cmd.rd_back ? ring_addr :
                     (cmd.rd_front | cmd.scan_first) ? head_reg : scan_addr_reg;

    always_comb
    begin
        head_next      = head_reg;
        occ_next       = occ_reg;
        scan_addr_next = scan_addr_reg;
        cmp_idx_next   = cmp_idx_reg;
        if (cmd.clr)
        begin
            head_next = '0;
            occ_next  = '0;
        end
        if (cmd.wr_front)
        begin
            head_next = head_dec;
        end
        if (cmd.rd_front)
        begin
            head_next = head_inc;
        end
        if (wr_en)
        begin
            occ_next = occ_reg + 1'b1;
        end
        if (cmd.rd_back | cmd.rd_front)
        begin
            occ_next = occ_reg - 1'b1;
        end
        if (cmd.scan_first)
        begin
            scan_addr_next = head_inc;
            cmp_idx_next   = '0;
        end
        if (cmd.scan_next)
        begin
            scan_addr_next = scan_inc;
            cmp_idx_next   = cmp_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            cmd_reg <= s_tuser;
            val_reg <= s_tdata;
        end
        scan_addr_reg <= scan_addr_next;
        cmp_idx_reg   <= cmp_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            occ_reg  <= occ_next;
        end
    end

    // output register, count reflects the state after the command
    assign idx_ext   = {4'b0, cmp_idx_reg};
    assign count_ext = {5'b0, occ_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg  <= cmd.out_pop ? rd_data_reg : '0;
            out_pos_reg    <= cmd.out_pos ? idx_ext[dq_pkg::POS_W-1:0] : '0;
            out_status_reg <= cmd.out_status;
            out_count_reg  <= count_ext[dq_pkg::COUNT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_count_reg, out_pos_reg, out_value_reg};
    assign m_tuser  = out_status_reg;

    assign cmp_plus = {1'b0, cmp_idx_reg} + (AW + 1)'(1);
    assign occ_ext  = (AW + 1)'(occ_reg);

    assign stat.cmd       = cmd_reg;
    assign stat.empty     = (occ_reg == '0);
    assign stat.full      = (occ_reg == FULL_C);
    assign stat.hit       = (rd_data_reg == val_reg);
    assign stat.scan_last = (cmp_plus == occ_ext);
    assign stat.out_free  = ~out_valid_reg | m_tready;

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !stat.full)
        else $error("push issued on a full ring");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_back | cmd.rd_front) |-> !stat.empty)
        else $error("pop issued on an empty ring");
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_C)
        else $error("occupancy beyond depth");
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an unsent beat");
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_next |-> (!stat.scan_last && $past(rd_en)))
        else $error("scan stepped past the last entry");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue_core.sv =====
// top level of the double-ended queue core: sequencer plus datapath
// depends on dq_pkg, dq_ctrl and dq_datapath
//
// usage:
//   slave channel: s_tuser carries the command (push back, push front, pop back,
//   pop front, find, clear), s_tdata the value pushed or searched for
//   master channel: one result beat per command; m_tdata/m_tuser fields listed at the ports
//   command steps, one command at a time, when the output is free:
//     push, clear, unused codes: accept, then execute and load the result
//     pop: accept, then a registered read of the ring store, then load the result
//     find: accept, read the head entry, then compare one entry after another from
//           the head until a match or the last entry, then load; the scan reads one entry
//           per cycle through the single read port of the ring store
//   result beat appears in the cycle after the last working cycle of its command
//   reset clears head, occupancy and the output valid; the ring store is not
//   cleared, since only entries that hold queued values are ever read
//   a new command beat is taken while a result beat still waits; if the
//   receiver stalls, the next result is held inside until the output frees
`default_nettype none

module double_ended_queue_core #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // data_value[31:0]
    input  wire logic [dq_pkg::S_DATA_W-1:0] s_tdata,
    // cmd[2:0]
    input  wire logic [dq_pkg::S_USER_W-1:0] s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // out_value[31:0], found_position[35:32], entry_count[40:36], zero pad
    output logic [dq_pkg::M_DATA_W-1:0]      m_tdata,
    // status[1:0]
    output logic [dq_pkg::M_USER_W-1:0]      m_tuser
);

    dq_pkg::dp_cmd_t  dp_cmd;
    dq_pkg::dp_stat_t dp_stat;

    // sequencer: one command at a time, result held until the output frees
    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // ring store with pointers and the result register
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
